// ===== design/rex_pkg.sv =====
// Package for the ring exclusion hop update block.
// Holds field widths, opcodes, result status codes, register defaults and the
// command and status structs between controller and datapath. No dependencies.
package rex_pkg;

  // Fixed field widths of the channels
  localparam int OPCODE_W   = 2;
  localparam int SITE_FW    = 7;
  localparam int DRAW_W     = 16;
  localparam int STEP_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_FW   = 8;
  localparam int CROSS_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PLACE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ATTEMPT = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DRAW_FAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARM_UP    = 2'd2;

  // Register reset values
  localparam logic [DRAW_W-1:0]  THRESHOLD_RST  = 16'd32768;
  localparam logic [SITE_FW-1:0] CHECK_SITE_RST = 7'd10;
  localparam logic [STEP_W-1:0]  WARM_UP_RST    = 32'd1000;

  typedef struct packed {
    logic accept;      // latch the input transaction, issue first reads
    logic look_next;   // read occupancy of the site ahead
    logic place;       // resolve a place operation
    logic hop;         // resolve a hop attempt
    logic vacate;      // free the site that was left
    logic clear_step;  // clear one occupancy entry
    logic clear_done;  // zero the counters and record a clear result
    logic reject;      // record a rejected operation
    logic load_out;    // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                part_ok;
    logic                hop_go;
    logic                clear_last;
  } sts_t;

endpackage

// ===== design/rex_chan_if.sv =====
// Channel interfaces of the ring exclusion hop update block: input items,
// result items and configuration writes. Depends on rex_pkg for widths.
interface rex_in_if;
  logic                          valid;
  logic                          ready;
  logic [rex_pkg::OPCODE_W-1:0]  opcode;
  logic [rex_pkg::SITE_FW-1:0]   site;
  logic [rex_pkg::SITE_FW-1:0]   particle;
  logic [rex_pkg::DRAW_W-1:0]    draw;
  logic [rex_pkg::STEP_W-1:0]    step_number;

  modport source (output valid, opcode, site, particle, draw, step_number, input ready);
  modport sink   (input valid, opcode, site, particle, draw, step_number, output ready);
endinterface

interface rex_out_if;
  logic                          valid;
  logic                          ready;
  logic [rex_pkg::STATUS_W-1:0]  status;
  logic                          hopped;
  logic [rex_pkg::SITE_FW-1:0]   position;
  logic [rex_pkg::COUNT_FW-1:0]  particle_total;
  logic [rex_pkg::CROSS_W-1:0]   crossings;

  modport source (output valid, status, hopped, position, particle_total, crossings,
                  input ready);
  modport sink   (input valid, status, hopped, position, particle_total, crossings,
                  output ready);
endinterface

interface rex_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rex_pkg::CFG_IDX_W-1:0]   index;
  logic [rex_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rex_dp.sv =====
// Datapath of the ring exclusion hop update block: occupancy and position
// memories, counters, configuration registers and the result register.
// Depends on rex_pkg; driven by rex_ctrl through rex_pkg::cmd_t.
module rex_dp #(
  parameter int SITES = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rex_pkg::cmd_t                   cmd_i,
  output rex_pkg::sts_t                   sts_o,
  input  logic [rex_pkg::OPCODE_W-1:0]    in_opcode_i,
  input  logic [rex_pkg::SITE_FW-1:0]     in_site_i,
  input  logic [rex_pkg::SITE_FW-1:0]     in_particle_i,
  input  logic [rex_pkg::DRAW_W-1:0]      in_draw_i,
  input  logic [rex_pkg::STEP_W-1:0]      in_step_i,
  input  logic                            cfg_we_i,
  input  logic [rex_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rex_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [rex_pkg::STATUS_W-1:0]    out_status_o,
  output logic                            out_hopped_o,
  output logic [rex_pkg::SITE_FW-1:0]     out_position_o,
  output logic [rex_pkg::COUNT_FW-1:0]    out_total_o,
  output logic [rex_pkg::CROSS_W-1:0]     out_crossings_o
);

  localparam int SiteW = $clog2(SITES);
  localparam int CntW  = $clog2(SITES + 1);
  localparam int CmpW  = (SiteW > rex_pkg::SITE_FW) ? SiteW : rex_pkg::SITE_FW;
  localparam int PartW = (CntW > rex_pkg::SITE_FW) ? CntW : rex_pkg::SITE_FW;
  localparam logic [SiteW-1:0] LastSite = SiteW'(SITES - 1);

  // Memories
  logic             occ_mem [SITES];
  logic [SiteW-1:0] pos_mem [SITES];

  // Configuration and counters
  logic [rex_pkg::DRAW_W-1:0]  thr_q;
  logic [rex_pkg::SITE_FW-1:0] chk_q;
  logic [rex_pkg::STEP_W-1:0]  warm_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [rex_pkg::CROSS_W-1:0] cross_q, cross_d;
  logic [SiteW-1:0]            clr_cnt_q, clr_cnt_d;

  // Latched operation
  logic [rex_pkg::OPCODE_W-1:0] op_q;
  logic [rex_pkg::SITE_FW-1:0]  site_q;
  logic [rex_pkg::SITE_FW-1:0]  part_q;
  logic [rex_pkg::DRAW_W-1:0]   draw_q;
  logic [rex_pkg::STEP_W-1:0]   step_q;

  // Registered memory read data
  logic             occ_rd_q;
  logic [SiteW-1:0] pos_rd_q;

  // Result staging
  logic [rex_pkg::STATUS_W-1:0] res_status_q;
  logic                         res_hopped_q;
  logic [rex_pkg::SITE_FW-1:0]  res_pos_q;

  logic [SiteW-1:0] next_site;
  logic             site_ok, count_ok, place_ok, place_go, hop_go, hop_commit, count_hit;
  logic             occ_we, occ_wdata, occ_re;
  logic [SiteW-1:0] occ_waddr, occ_raddr;

  assign next_site  = (pos_rd_q == LastSite) ? '0 : pos_rd_q + 1'b1;
  assign site_ok    = 32'(site_q) < SITES;
  assign count_ok   = count_q < CntW'(SITES);
  assign place_ok   = site_ok && count_ok;
  assign place_go   = cmd_i.place && place_ok && !occ_rd_q;
  assign hop_go     = !occ_rd_q && (draw_q <= thr_q);
  assign hop_commit = cmd_i.hop && hop_go;
  assign count_hit  = (CmpW'(pos_rd_q) == CmpW'(chk_q)) && (step_q > warm_q)
                      && (cross_q != '1);

  assign sts_o.op         = op_q;
  assign sts_o.part_ok    = PartW'(part_q) < PartW'(count_q);
  assign sts_o.hop_go     = hop_go;
  assign sts_o.clear_last = clr_cnt_q == LastSite;

  // Occupancy port selection: one write and one read per cycle
  always_comb begin
    occ_we    = 1'b0;
    occ_wdata = 1'b0;
    occ_waddr = clr_cnt_q;
    priority if (cmd_i.clear_step) begin
      occ_we = 1'b1;
    end else if (place_go) begin
      occ_we    = 1'b1;
      occ_wdata = 1'b1;
      occ_waddr = SiteW'(site_q);
    end else if (hop_commit) begin
      occ_we    = 1'b1;
      occ_wdata = 1'b1;
      occ_waddr = next_site;
    end else if (cmd_i.vacate) begin
      occ_we    = 1'b1;
      occ_waddr = pos_rd_q;
    end else begin
      occ_we = 1'b0;
    end
  end

  assign occ_re    = cmd_i.accept || cmd_i.look_next;
  assign occ_raddr = cmd_i.accept ? SiteW'(in_site_i) : next_site;

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_rd_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_go) begin
      pos_mem[SiteW'(count_q)] <= SiteW'(site_q);
    end else if (hop_commit) begin
      pos_mem[SiteW'(part_q)] <= next_site;
    end
    if (cmd_i.accept) begin
      pos_rd_q <= pos_mem[SiteW'(in_particle_i)];
    end
  end

  always_comb begin
    count_d   = count_q;
    cross_d   = cross_q;
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clear_step) begin
      clr_cnt_d = (clr_cnt_q == LastSite) ? '0 : clr_cnt_q + 1'b1;
    end
    if (cmd_i.clear_done) begin
      count_d = '0;
      cross_d = '0;
    end else if (place_go) begin
      count_d = count_q + 1'b1;
    end else if (hop_commit && count_hit) begin
      cross_d = cross_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= rex_pkg::THRESHOLD_RST;
      chk_q     <= rex_pkg::CHECK_SITE_RST;
      warm_q    <= rex_pkg::WARM_UP_RST;
      count_q   <= '0;
      cross_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      count_q   <= count_d;
      cross_q   <= cross_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rex_pkg::CFG_THRESHOLD:  thr_q  <= cfg_data_i[rex_pkg::DRAW_W-1:0];
          rex_pkg::CFG_CHECK_SITE: chk_q  <= cfg_data_i[rex_pkg::SITE_FW-1:0];
          rex_pkg::CFG_WARM_UP:    warm_q <= cfg_data_i[rex_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Operation latch, result staging and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_opcode_i;
      site_q <= in_site_i;
      part_q <= in_particle_i;
      draw_q <= in_draw_i;
      step_q <= in_step_i;
    end

    priority if (cmd_i.reject) begin
      res_status_q <= rex_pkg::ST_REJECT;
      res_hopped_q <= 1'b0;
      res_pos_q    <= '0;
    end else if (cmd_i.clear_done) begin
      res_status_q <= rex_pkg::ST_DONE;
      res_hopped_q <= 1'b0;
      res_pos_q    <= '0;
    end else if (cmd_i.place) begin
      res_hopped_q <= 1'b0;
      if (!place_ok) begin
        res_status_q <= rex_pkg::ST_REJECT;
        res_pos_q    <= '0;
      end else begin
        res_status_q <= occ_rd_q ? rex_pkg::ST_OCCUPIED : rex_pkg::ST_DONE;
        res_pos_q    <= site_q;
      end
    end else if (cmd_i.hop) begin
      if (occ_rd_q) begin
        res_status_q <= rex_pkg::ST_BLOCKED;
        res_hopped_q <= 1'b0;
        res_pos_q    <= rex_pkg::SITE_FW'(pos_rd_q);
      end else if (!hop_go) begin
        res_status_q <= rex_pkg::ST_DRAW_FAIL;
        res_hopped_q <= 1'b0;
        res_pos_q    <= rex_pkg::SITE_FW'(pos_rd_q);
      end else begin
        res_status_q <= rex_pkg::ST_DONE;
        res_hopped_q <= 1'b1;
        res_pos_q    <= rex_pkg::SITE_FW'(next_site);
      end
    end else begin
      res_hopped_q <= res_hopped_q;
    end

    if (cmd_i.load_out) begin
      out_status_o    <= res_status_q;
      out_hopped_o    <= res_hopped_q;
      out_position_o  <= res_pos_q;
      out_total_o     <= rex_pkg::COUNT_FW'(count_q);
      out_crossings_o <= cross_q;
    end
  end

endmodule

// ===== design/rex_ctrl.sv =====
// Controller of the ring exclusion hop update block: sequences each operation
// and owns the input ready and the output valid. Depends on rex_pkg.
module rex_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rex_pkg::sts_t sts_i,
  output rex_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_HOP   = 3'd3;
  localparam logic [2:0] S_VAC   = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.op)
          rex_pkg::OP_CLEAR: state_d = S_CLR;
          rex_pkg::OP_PLACE: begin
            cmd_o.place = 1'b1;
            state_d     = S_DONE;
          end
          rex_pkg::OP_ATTEMPT: begin
            if (sts_i.part_ok) begin
              cmd_o.look_next = 1'b1;
              state_d         = S_HOP;
            end else begin
              cmd_o.reject = 1'b1;
              state_d      = S_DONE;
            end
          end
          default: begin
            cmd_o.reject = 1'b1;
            state_d      = S_DONE;
          end
        endcase
      end
      S_HOP: begin
        cmd_o.hop = 1'b1;
        state_d   = sts_i.hop_go ? S_VAC : S_DONE;
      end
      S_VAC: begin
        cmd_o.vacate = 1'b1;
        state_d      = S_DONE;
      end
      S_CLR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          cmd_o.clear_done = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register has room
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/ring_exclusion_hop_update.sv =====
// Top level of the ring exclusion hop update block: one periodic ring of SITES
// sites with one-way particle hops. Depends on rex_pkg, rex_chan_if, rex_ctrl, rex_dp.
//
// One transaction at a time is taken on in_i; each gives one result on out_o,
// held in an output register so the next transaction can start while the
// result waits. After reset the block clears its whole occupancy memory before
// in_i.ready rises; configuration writes are taken at any time. A place or a
// rejected transaction is resolved in the dispatch state; a hop attempt reads
// the site ahead there, then resolves in the hop state; a clear walks every site
// in turn in the clear state. The result then waits in the done state until the
// output register has room; the next transaction can be accepted in the cycle
// after the load. The occupancy memory has one write port, so a hop marks the
// new site in the hop state and frees the old one in the vacate state.
module ring_exclusion_hop_update #(
  parameter int SITES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rex_in_if.sink       in_i,
  rex_out_if.source    out_o,
  rex_cfg_if.sink      cfg_i
);

  rex_pkg::cmd_t cmd;
  rex_pkg::sts_t sts;
  logic          in_ready, out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  rex_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rex_dp #(
    .SITES (SITES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_opcode_i     (in_i.opcode),
    .in_site_i       (in_i.site),
    .in_particle_i   (in_i.particle),
    .in_draw_i       (in_i.draw),
    .in_step_i       (in_i.step_number),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_status_o    (out_o.status),
    .out_hopped_o    (out_o.hopped),
    .out_position_o  (out_o.position),
    .out_total_o     (out_o.particle_total),
    .out_crossings_o (out_o.crossings)
  );

endmodule

// ===== verif/ring_exclusion_hop_update_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ring exclusion hop update block: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on rex_pkg and the channel interfaces in rex_chan_if.
module ring_exclusion_hop_update_checker
  import rex_pkg::*;
#(
  parameter int SITES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rex_in_if           in_i,
  rex_out_if          out_i,
  rex_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned results_o,
  output int unsigned hops_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hopped;
    logic [SITE_FW-1:0]  position;
    logic [COUNT_FW-1:0] particle_total;
    logic [CROSS_W-1:0]  crossings;
  } ring_result_t;

  // Shadow copy of the ring and its registers
  logic [SITES-1:0]    occupied;
  logic [SITE_FW-1:0]  where_is [SITES];
  logic [COUNT_FW-1:0] n_particles;
  logic [CROSS_W-1:0]  n_crossings;
  logic [DRAW_W-1:0]   threshold;
  logic [SITE_FW-1:0]  check_site;
  logic [STEP_W-1:0]   warm_up;

  ring_result_t expected_q [$];
  ring_result_t predicted;
  int           errs;

  function automatic ring_result_t ring_apply(input logic [OPCODE_W-1:0] op,
                                              input logic [SITE_FW-1:0]  site,
                                              input logic [SITE_FW-1:0]  idx,
                                              input logic [DRAW_W-1:0]   draw,
                                              input logic [STEP_W-1:0]   step);
    ring_result_t       r;
    logic [SITE_FW-1:0] here;
    logic [SITE_FW-1:0] ahead;
    r        = '0;
    r.status = ST_REJECT;
    case (op)
      OP_CLEAR: begin
        occupied    = '0;
        n_particles = '0;
        n_crossings = '0;
        r.status    = ST_DONE;
      end
      OP_PLACE: begin
        if (n_particles < SITES) begin
          r.position = site;
          if (occupied[site]) begin
            r.status = ST_OCCUPIED;
          end else begin
            occupied[site]                 = 1'b1;
            where_is[SITE_FW'(n_particles)] = site;
            n_particles                    = n_particles + 1'b1;
            r.status                       = ST_DONE;
          end
        end
      end
      OP_ATTEMPT: begin
        if (idx < n_particles) begin
          here       = where_is[idx];
          ahead      = (here == SITES - 1) ? '0 : here + 1'b1;
          r.position = here;
          if (occupied[ahead]) begin
            r.status = ST_BLOCKED;
          end else if (draw > threshold) begin
            r.status = ST_DRAW_FAIL;
          end else begin
            occupied[here]  = 1'b0;
            occupied[ahead] = 1'b1;
            where_is[idx]   = ahead;
            // count only hops out of the check site once warm-up is over; saturate
            if (here == check_site && step > warm_up && n_crossings != '1) begin
              n_crossings = n_crossings + 1'b1;
            end
            r.position = ahead;
            r.hopped   = 1'b1;
            r.status   = ST_DONE;
          end
        end
      end
      default: ;
    endcase
    r.particle_total = n_particles;
    r.crossings      = n_crossings;
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [CROSS_W-1:0] want,
                                    input logic [CROSS_W-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied    = '0;
      n_particles = '0;
      n_crossings = '0;
      threshold   = THRESHOLD_RST;
      check_site  = CHECK_SITE_RST;
      warm_up     = WARM_UP_RST;
      expected_q.delete();
      fail_count_o <= 0;
      results_o    <= 0;
      hops_o       <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_THRESHOLD:  threshold  = cfg_i.data[DRAW_W-1:0];
          CFG_CHECK_SITE: check_site = cfg_i.data[SITE_FW-1:0];
          CFG_WARM_UP:    warm_up    = cfg_i.data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        predicted = ring_apply(in_i.opcode, in_i.site, in_i.particle, in_i.draw,
                               in_i.step_number);
        expected_q.push_back(predicted);
        if (predicted.hopped) hops_o <= hops_o + 1;
      end
      if (out_i.valid && out_i.ready) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no transaction outstanding, expected none, got status %0d",
                   $time, out_i.status);
          fail_count_o <= fail_count_o + 1;
        end else begin
          predicted = expected_q.pop_front();
          errs = field_diff("status", CROSS_W'(predicted.status), CROSS_W'(out_i.status))
               + field_diff("hopped", CROSS_W'(predicted.hopped), CROSS_W'(out_i.hopped))
               + field_diff("position", CROSS_W'(predicted.position),
                            CROSS_W'(out_i.position))
               + field_diff("particle_total", CROSS_W'(predicted.particle_total),
                            CROSS_W'(out_i.particle_total))
               + field_diff("crossings", predicted.crossings, out_i.crossings);
          fail_count_o <= fail_count_o + errs;
        end
      end
    end
  end

endmodule

// ===== verif/ring_exclusion_hop_update_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the ring exclusion hop update block: clock, reset, item and
// register stimulus, result back-pressure and the verdict.
// Depends on rex_pkg, rex_chan_if, the block and ring_exclusion_hop_update_checker.
module ring_exclusion_hop_update_test;
  import rex_pkg::*;

  localparam int SITES        = 128;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 6;
  localparam logic [OPCODE_W-1:0]  OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  rex_in_if  in_if ();
  rex_out_if out_if ();
  rex_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned results;
  int unsigned hops;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned directed_items;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Register values currently loaded, used to aim the stimulus
  logic [DRAW_W-1:0]  cur_threshold;
  logic [SITE_FW-1:0] cur_check;
  logic [STEP_W-1:0]  cur_warm;

  ring_exclusion_hop_update #(.SITES(SITES)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  ring_exclusion_hop_update_checker #(.SITES(SITES)) hop_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .results_o    (results),
    .hops_o       (hops)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d of %0d results back",
               cycles, results, sent);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [SITE_FW-1:0] any_site();
    return SITE_FW'($urandom);
  endfunction

  // Draws bunch around the threshold so both sides of the compare are hit
  function automatic logic [DRAW_W-1:0] pick_draw();
    case ($urandom_range(0, 9))
      0:       return cur_threshold;
      1:       return cur_threshold + 1'b1;
      2:       return '0;
      3:       return '1;
      default: return DRAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return cur_warm;
      1:       return cur_warm + 1'b1;
      2:       return cur_warm - 1'b1;
      3:       return '1;
      4:       return '0;
      default: return STEP_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SITE_FW-1:0] site,
                           input logic [SITE_FW-1:0] idx, input logic [DRAW_W-1:0] draw,
                           input logic [STEP_W-1:0] step);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.site        <= site;
    in_if.particle    <= idx;
    in_if.draw        <= draw;
    in_if.step_number <= step;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // Drop valid and hold until every transaction has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (results != sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Upper data bits are junk on purpose; the block must ignore them
  task automatic configure(input logic [DRAW_W-1:0] thr, input logic [SITE_FW-1:0] chk,
                           input logic [STEP_W-1:0] warm);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_THRESHOLD, {junk[31:16], thr});
    write_reg(CFG_CHECK_SITE, {junk[24:0], chk});
    write_reg(CFG_WARM_UP, warm);
    cfg_if.valid  <= 1'b0;
    cur_threshold = thr;
    cur_check     = chk;
    cur_warm      = warm;
  endtask

  task automatic run_directed();
    send_item(OP_CLEAR, any_site(), any_site(), pick_draw(), $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd0, 16'd0, $urandom);          // empty ring
    send_item(OP_UNUSED, any_site(), any_site(), pick_draw(), $urandom);
    send_item(OP_PLACE, 7'd0, any_site(), pick_draw(), $urandom);
    send_item(OP_PLACE, 7'd0, any_site(), pick_draw(), $urandom);      // site taken
    send_item(OP_PLACE, 7'd127, any_site(), pick_draw(), $urandom);
    send_item(OP_PLACE, 7'd10, any_site(), pick_draw(), $urandom);
    send_item(OP_PLACE, 7'd11, any_site(), pick_draw(), $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd0, 16'd0, 32'd0);
    send_item(OP_ATTEMPT, any_site(), 7'd1, THRESHOLD_RST, $urandom);  // wraps to site 0
    send_item(OP_ATTEMPT, any_site(), 7'd0, THRESHOLD_RST + 1'b1, $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd2, 16'hFFFF, $urandom);       // blocked ahead
    send_item(OP_ATTEMPT, any_site(), 7'd3, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_ATTEMPT, any_site(), 7'd3, 16'd0, $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd2, 16'd0, WARM_UP_RST);       // not yet counted
    send_item(OP_ATTEMPT, any_site(), 7'd2, 16'd0, $urandom);
    send_item(OP_PLACE, 7'd10, any_site(), pick_draw(), $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd4, 16'd0, WARM_UP_RST + 1'b1); // counted crossing
    send_item(OP_ATTEMPT, any_site(), 7'd127, 16'd0, $urandom);
    send_item(OP_PLACE, 7'd127, any_site(), pick_draw(), $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd5, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, any_site(), any_site(), pick_draw(), $urandom);
    send_item(OP_ATTEMPT, any_site(), 7'd0, 16'd0, $urandom);
  endtask

  task automatic run_episode();
    int                 roll;
    int                 n_place;
    int                 count;
    int                 j;
    int                 tmp;
    int                 order [SITES];
    logic [SITES-1:0]   taken;
    logic [SITE_FW-1:0] s;
    logic [SITE_FW-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // stray transactions of any kind
      repeat ($urandom_range(1, 5)) begin
        send_item(OPCODE_W'($urandom), any_site(), any_site(), pick_draw(), pick_step());
      end
    end else if (roll < 9) begin
      // fill every site, then push a full ring
      send_item(OP_CLEAR, any_site(), any_site(), pick_draw(), pick_step());
      for (int i = 0; i < SITES; i++) order[i] = i;
      for (int i = SITES - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < SITES; i++) begin
        send_item(OP_PLACE, SITE_FW'(order[i]), any_site(), pick_draw(), pick_step());
      end
      send_item(OP_PLACE, any_site(), any_site(), pick_draw(), pick_step());
      repeat (4) send_item(OP_ATTEMPT, any_site(), any_site(), pick_draw(), pick_step());
    end else begin
      send_item(OP_CLEAR, any_site(), any_site(), pick_draw(), pick_step());
      n_place = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 16);
      taken   = '0;
      count   = 0;
      while (count < n_place) begin
        if (count > 0 && $urandom_range(0, 9) == 0) begin
          // aim at a site already holding a particle
          s = any_site();
          while (!taken[s]) s = s + 1'b1;
        end else begin
          // cluster behind the check site so crossings happen
          if ($urandom_range(0, 1)) s = cur_check - SITE_FW'($urandom_range(0, 2 * n_place));
          else s = any_site();
          while (taken[s]) s = s + 1'b1;
          taken[s] = 1'b1;
          count++;
        end
        send_item(OP_PLACE, s, any_site(), pick_draw(), pick_step());
      end
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 9) == 0) idx = SITE_FW'($urandom_range(count, SITES - 1));
        else idx = SITE_FW'($urandom_range(0, count - 1));
        send_item(OP_ATTEMPT, any_site(), idx, pick_draw(), pick_step());
      end
    end
  endtask

  initial begin
    int unsigned quota;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_CLEAR;
    in_if.site        = '0;
    in_if.particle    = '0;
    in_if.draw        = '0;
    in_if.step_number = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_THRESHOLD;
    cfg_if.data       = '0;
    send_idle_pct     = 22;
    recv_idle_pct     = 70;
    cur_threshold     = THRESHOLD_RST;
    cur_check         = CHECK_SITE_RST;
    cur_warm          = WARM_UP_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    directed_items = sent;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase / 2)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        1: configure(16'hFFFF, 7'd0, 32'd0);
        2: begin
          write_reg(CFG_UNUSED, $urandom);
          configure(16'd0, 7'd127, 32'hFFFF_FFFF);
        end
        3: configure(DRAW_W'($urandom), any_site(), $urandom_range(0, 3000));
        4: configure(16'd1, 7'd127, 32'd0);
        5: configure(DRAW_W'($urandom), any_site(), 32'd1000);
        default: ;
      endcase
      // absolute target per phase so overshoot does not pile up
      quota = (phase + 1) * RANDOM_ITEMS / PHASES;
      do run_episode(); while (sent < quota);
    end

    drain();
    repeat (16) @(posedge clk);
    $display("%0d transactions (%0d directed) over %0d register settings and three idle mixes",
             sent, directed_items, PHASES);
    $display("%0d results compared, %0d hops predicted, %0d mismatches",
             results, hops, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
